### hw/rtl/lwbt_pkg.sv
// Package: shared types, constants and codes for the lazy write buffer block.
package lwbt_pkg;

    localparam int ADDR_BITS   = 10;
    localparam int BUF_ENTRIES = 8;
    localparam int DATA_BITS   = 32;
    localparam int STORE_DEPTH = 1 << ADDR_BITS;
    localparam int IDX_BITS    = $clog2(BUF_ENTRIES);
    localparam int CNT_BITS    = $clog2(BUF_ENTRIES + 1);

    typedef enum logic [2:0] {
        OP_BEGIN    = 3'd0,
        OP_TREAD    = 3'd1,
        OP_TWRITE   = 3'd2,
        OP_COMMIT   = 3'd3,
        OP_ABORT    = 3'd4,
        OP_DREAD    = 3'd5,
        OP_DWRITE   = 3'd6,
        OP_NOP      = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        PH_NONE      = 2'd0,
        PH_ACTIVE    = 2'd1,
        PH_COMMITTED = 2'd2,
        PH_ABORTED   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_NO_TXN = 2'd1,
        ST_FULL   = 2'd2,
        ST_RSVD   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_FLUSH,
        S_OUT
    } state_t;

endpackage

### hw/rtl/lwbt_ram.sv
// Generic single-port synchronous RAM with registered read.
module lwbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### hw/rtl/lazy_write_buffer_transaction.sv
// Top level: shared word store with a lazy-versioning transactional write buffer.
//
// One request per operation, one result per request. After reset the store
// is cleared by a pass over all 2**ADDR_BITS (1024) words, during which no
// request is taken. Begin, abort, txn write, direct write, no-op and rejected
// requests go from accept through the output state to the result, and so
// does a txn read that hits the buffer. Txn reads that miss the buffer and
// direct reads pass through a read state first because the store RAM read is
// registered. Commit walks every buffer slot through the store's single write
// port in a flush state before the output state. The buffer's address/value
// entries live in flip-flops (combinational associative match); the store is
// one RAM instance. A new request is not accepted while the previous result
// waits, only once that result has been taken or at the same edge it is taken.
module lazy_write_buffer_transaction (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [9:0]  address,
    input  logic signed [31:0] write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] read_data,
    output logic [1:0]  status,
    output logic [1:0]  txn_phase_out,
    output logic [3:0]  buffered_count
);

    localparam int AB = lwbt_pkg::ADDR_BITS;
    localparam int NB = lwbt_pkg::BUF_ENTRIES;
    localparam int IB = lwbt_pkg::IDX_BITS;
    localparam int CB = lwbt_pkg::CNT_BITS;

    lwbt_pkg::state_t state_reg, state_next;
    logic [AB-1:0] clr_reg, clr_next;
    logic [IB-1:0] fl_reg, fl_next;
    lwbt_pkg::phase_t phase_reg, phase_next;
    logic [NB-1:0] valid_reg, valid_next;
    logic [AB-1:0] eaddr_reg [NB];
    logic [31:0]   eval_reg [NB];
    logic          hold_reg, hold_next;   // result register full
    logic [31:0]   rd_reg, rd_next;
    logic [1:0]    st_reg, st_next;
    logic          rd_from_ram_reg, rd_from_ram_next;

    logic          ram_we;
    logic [AB-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata;

    logic          ewr;
    logic [IB-1:0] ewr_idx;

    logic          hit;
    logic [IB-1:0] hit_idx, free_idx;
    logic          has_free;
    logic [CB-1:0] cnt;
    logic          take;
    logic          out_free;

    lwbt_ram #(.WIDTH(32), .DEPTH(lwbt_pkg::STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Match and free search over the buffer (independent per entry).
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        cnt      = '0;
        for (int i = NB - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && eaddr_reg[i] == address[AB-1:0])
            begin
                hit     = 1'b1;
                hit_idx = IB'(i);
            end
            if (!valid_reg[i])
            begin
                has_free = 1'b1;
                free_idx = IB'(i);
            end
        end
        for (int i = 0; i < NB; i++)
        begin
            cnt = cnt + CB'(valid_reg[i]);
        end
    end

    assign out_free = !hold_reg || !out_stall;
    assign in_stall = !(state_reg == lwbt_pkg::S_IDLE && out_free);
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        fl_next          = fl_reg;
        phase_next       = phase_reg;
        valid_next       = valid_reg;
        hold_next        = hold_reg && out_stall;
        rd_next          = rd_reg;
        st_next          = st_reg;
        rd_from_ram_next = 1'b0;
        ram_we           = 1'b0;
        ram_addr         = address[AB-1:0];
        ram_wdata        = write_data;
        ewr              = 1'b0;
        ewr_idx          = hit_idx;
        unique case (state_reg)
            lwbt_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = lwbt_pkg::S_IDLE;
                end
            end
            lwbt_pkg::S_IDLE:
            begin
                if (take)
                begin
                    rd_next    = '0;
                    st_next    = lwbt_pkg::ST_DONE;
                    state_next = lwbt_pkg::S_OUT;
                    unique case (lwbt_pkg::opcode_t'(opcode))
                        lwbt_pkg::OP_BEGIN:
                        begin
                            valid_next = '0;
                            phase_next = lwbt_pkg::PH_ACTIVE;
                        end
                        lwbt_pkg::OP_TREAD:
                        begin
                            if (phase_reg != lwbt_pkg::PH_ACTIVE)
                            begin
                                st_next = lwbt_pkg::ST_NO_TXN;
                            end
                            else if (hit)
                            begin
                                rd_next = eval_reg[hit_idx];
                            end
                            else
                            begin
                                state_next = lwbt_pkg::S_READ;
                            end
                        end
                        lwbt_pkg::OP_TWRITE:
                        begin
                            if (phase_reg != lwbt_pkg::PH_ACTIVE)
                            begin
                                st_next = lwbt_pkg::ST_NO_TXN;
                            end
                            else if (hit)
                            begin
                                ewr = 1'b1;
                            end
                            else if (has_free)
                            begin
                                ewr                  = 1'b1;
                                ewr_idx              = free_idx;
                                valid_next[free_idx] = 1'b1;
                            end
                            else
                            begin
                                st_next = lwbt_pkg::ST_FULL;
                            end
                        end
                        lwbt_pkg::OP_COMMIT:
                        begin
                            if (phase_reg != lwbt_pkg::PH_ACTIVE)
                            begin
                                st_next = lwbt_pkg::ST_NO_TXN;
                            end
                            else
                            begin
                                fl_next    = '0;
                                state_next = lwbt_pkg::S_FLUSH;
                            end
                        end
                        lwbt_pkg::OP_ABORT:
                        begin
                            if (phase_reg != lwbt_pkg::PH_ACTIVE)
                            begin
                                st_next = lwbt_pkg::ST_NO_TXN;
                            end
                            else
                            begin
                                valid_next = '0;
                                phase_next = lwbt_pkg::PH_ABORTED;
                            end
                        end
                        lwbt_pkg::OP_DREAD:
                        begin
                            state_next = lwbt_pkg::S_READ;
                        end
                        lwbt_pkg::OP_DWRITE:
                        begin
                            ram_we = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            lwbt_pkg::S_READ:
            begin
                // RAM data arrives this cycle; capture into the result.
                rd_next          = ram_rdata;
                rd_from_ram_next = 1'b1;
                state_next       = lwbt_pkg::S_OUT;
            end
            lwbt_pkg::S_FLUSH:
            begin
                // Walk one slot per cycle; later slots never share an address.
                ram_we    = valid_reg[fl_reg];
                ram_addr  = eaddr_reg[fl_reg];
                ram_wdata = eval_reg[fl_reg];
                fl_next   = fl_reg + 1'b1;
                if (32'(fl_reg) == NB - 1)
                begin
                    valid_next = '0;
                    phase_next = lwbt_pkg::PH_COMMITTED;
                    state_next = lwbt_pkg::S_OUT;
                end
            end
            lwbt_pkg::S_OUT:
            begin
                hold_next  = 1'b1;
                state_next = lwbt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lwbt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lwbt_pkg::S_CLEAR;
            clr_reg   <= '0;
            fl_reg    <= '0;
            phase_reg <= lwbt_pkg::PH_NONE;
            valid_reg <= '0;
            hold_reg  <= 1'b0;
            rd_from_ram_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            fl_reg    <= fl_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
            hold_reg  <= hold_next;
            rd_from_ram_reg <= rd_from_ram_next;
        end
    end

    // Payload registers: buffer contents and result fields.
    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
        st_reg <= st_next;
        if (ewr)
        begin
            eaddr_reg[ewr_idx] <= address[AB-1:0];
            eval_reg[ewr_idx]  <= write_data;
        end
    end

    assign out_valid      = hold_reg;
    assign read_data      = rd_reg;
    assign status         = st_reg;
    assign txn_phase_out  = phase_reg;
    assign buffered_count = 4'(cnt);

    // No request is taken while the store is being cleared or flushed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lwbt_pkg::S_CLEAR || state_reg == lwbt_pkg::S_FLUSH) |-> in_stall)
        else $error("request taken during clear or flush");

    // A read result captured from the store follows a read state.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_from_ram_reg |-> $past(state_reg == lwbt_pkg::S_READ))
        else $error("store data captured outside a read");

    // The buffer is empty whenever no transaction is active.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != lwbt_pkg::PH_ACTIVE) |-> (valid_reg == '0))
        else $error("buffer holds entries outside a transaction");

    // A commit ends with an empty buffer and the committed phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lwbt_pkg::S_FLUSH && state_next == lwbt_pkg::S_OUT)
        |=> (valid_reg == '0 && phase_reg == lwbt_pkg::PH_COMMITTED))
        else $error("commit did not settle");

endmodule

### verif/testbench.sv
// Testbench for the lazy write buffer transaction block: directed and random requests.
`timescale 1ns / 100ps

module testbench;
    import lwbt_pkg::*;

    typedef struct packed {
        logic signed [31:0] rdata;
        status_t            st;
        phase_t             ph;
        logic [3:0]         cnt;
    } txn_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [9:0]  address;
    logic signed [31:0] write_data;
    logic        out_valid;
    logic        out_stall;
    logic signed [31:0] read_data;
    logic [1:0]  status;
    logic [1:0]  txn_phase_out;
    logic [3:0]  buffered_count;

    // Shadow copy of the block's state, advanced on every accepted request.
    logic [31:0] shadow_store [STORE_DEPTH];
    logic        slot_valid [BUF_ENTRIES];
    logic [9:0]  slot_addr [BUF_ENTRIES];
    logic [31:0] slot_value [BUF_ENTRIES];
    phase_t      shadow_phase;

    txn_result_t pending_results[$];
    int          error_count;
    int          cycle_count;
    bit          hold_off;
    int          hold_cycles;

    lazy_write_buffer_transaction u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .address        (address),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .status         (status),
        .txn_phase_out  (txn_phase_out),
        .buffered_count (buffered_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Cycle limit: slowest run is well under this (clear pass, commits, long stalls).
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Compute the result of one request and advance the shadow state.
    function automatic txn_result_t predict_result(opcode_t op, logic [9:0] a,
                                                   logic [31:0] wd);
        txn_result_t r;
        int          hit;
        int          free_slot;
        int          n;
        r.rdata = '0;
        r.st = ST_DONE;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < BUF_ENTRIES; i++)
        begin
            if (slot_valid[i] && slot_addr[i] == a && hit < 0)
                hit = i;
            if (!slot_valid[i] && free_slot < 0)
                free_slot = i;
        end
        // Txn reads and writes, commit and abort are refused outside an active transaction.
        if ((op == OP_TREAD || op == OP_TWRITE || op == OP_COMMIT || op == OP_ABORT)
            && shadow_phase != PH_ACTIVE)
            r.st = ST_NO_TXN;
        else
            case (op)
                OP_BEGIN:
                begin
                    for (int i = 0; i < BUF_ENTRIES; i++)
                        slot_valid[i] = 1'b0;
                    shadow_phase = PH_ACTIVE;
                end
                OP_TREAD:  r.rdata = (hit >= 0) ? slot_value[hit] : shadow_store[a];
                OP_TWRITE:
                begin
                    if (hit >= 0)
                        slot_value[hit] = wd;
                    else if (free_slot >= 0)
                    begin
                        slot_valid[free_slot] = 1'b1;
                        slot_addr[free_slot] = a;
                        slot_value[free_slot] = wd;
                    end
                    else
                        r.st = ST_FULL;
                end
                OP_COMMIT:
                begin
                    for (int i = 0; i < BUF_ENTRIES; i++)
                    begin
                        if (slot_valid[i])
                            shadow_store[slot_addr[i]] = slot_value[i];
                        slot_valid[i] = 1'b0;
                    end
                    shadow_phase = PH_COMMITTED;
                end
                OP_ABORT:
                begin
                    for (int i = 0; i < BUF_ENTRIES; i++)
                        slot_valid[i] = 1'b0;
                    shadow_phase = PH_ABORTED;
                end
                OP_DREAD:  r.rdata = shadow_store[a];
                OP_DWRITE: shadow_store[a] = wd;
                default:   ;
            endcase
        n = 0;
        for (int i = 0; i < BUF_ENTRIES; i++)
            if (slot_valid[i])
                n++;
        r.ph = shadow_phase;
        r.cnt = 4'(n);
        return r;
    endfunction

    // Short gap, occasionally a long one.
    function automatic int random_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(5, 30);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offer one request, hold it until taken, then drop valid for a gap if one is drawn.
    task automatic send_request(input opcode_t op, input logic [9:0] a,
                                input logic [31:0] wd);
        int          gap;
        txn_result_t expected;
        gap = random_gap();
        in_valid <= 1'b1;
        opcode <= op;
        address <= a;
        write_data <= wd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected = predict_result(op, a, wd);
        pending_results.insert(pending_results.size(), expected);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Receiver stall: random gaps, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 200)
                hold_off <= 1'b0;
        end
        else
            out_stall <= ($urandom_range(0, 3) == 0) ||
                         ($urandom_range(0, 49) == 0 ? 1'b1 : out_stall &&
                          $urandom_range(0, 5) != 0);
    end

    // Compare every taken result with the oldest expectation.
    always @(posedge clk)
    begin
        txn_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", read_data, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_data !== want.rdata)
                    report_mismatch("read_data", read_data, want.rdata);
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
                if (txn_phase_out !== want.ph)
                    report_mismatch("txn_phase_out", txn_phase_out, want.ph);
                if (buffered_count !== want.cnt)
                    report_mismatch("buffered_count", buffered_count, want.cnt);
            end
        end
    end

    function automatic logic [9:0] pick_addr(bit narrow);
        if (narrow)
            return 10'($urandom_range(0, 15));
        return 10'($urandom);
    endfunction

    // Edge cases: refused ops, overflow, updates, direct write under a txn.
    task automatic test_directed();
        send_request(OP_TREAD, 10'd5, 32'd0);
        send_request(OP_TWRITE, 10'd5, 32'h1);
        send_request(OP_COMMIT, 10'd0, 32'd0);
        send_request(OP_ABORT, 10'd0, 32'd0);
        send_request(OP_DREAD, 10'h3ff, 32'd0);
        send_request(OP_NOP, 10'h3ff, 32'hffffffff);
        send_request(OP_DWRITE, 10'h3ff, 32'h80000000);
        send_request(OP_BEGIN, 10'd0, 32'd0);
        for (int i = 0; i < BUF_ENTRIES; i++)
            send_request(OP_TWRITE, 10'(i * 100), 32'h7fffffff - i);
        send_request(OP_TWRITE, 10'd999, 32'h55555555);
        send_request(OP_TWRITE, 10'd0, 32'haaaaaaaa);
        send_request(OP_DWRITE, 10'd100, 32'h12345678);
        send_request(OP_TREAD, 10'd100, 32'd0);
        send_request(OP_TREAD, 10'h3ff, 32'd0);
        send_request(OP_BEGIN, 10'd0, 32'd0);
        send_request(OP_TWRITE, 10'd3, 32'd9);
        send_request(OP_COMMIT, 10'd0, 32'd0);
        send_request(OP_DREAD, 10'd3, 32'd0);
    endtask

    // Mostly well-formed transactions with random content, plus noise.
    task automatic test_random(input int count);
        int    sent;
        int    len;
        bit    narrow;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_request(opcode_t'($urandom_range(0, 7)), pick_addr(0), $urandom);
                sent++;
            end
            else
            begin
                narrow = $urandom_range(0, 1);
                len = $urandom_range(1, 14);
                send_request(OP_BEGIN, pick_addr(0), $urandom);
                for (int i = 0; i < len; i++)
                    send_request(opcode_t'($urandom_range(1, 2) == 1 ? OP_TREAD :
                                 ($urandom_range(0, 5) == 0 ?
                                  opcode_t'($urandom_range(5, 6)) : OP_TWRITE)),
                                 pick_addr(narrow), $urandom);
                case ($urandom_range(0, 3))
                    0: send_request(OP_ABORT, pick_addr(0), $urandom);
                    1: ;
                    default: send_request(OP_COMMIT, pick_addr(0), $urandom);
                endcase
                send_request(OP_DREAD, pick_addr(narrow), $urandom);
                sent += len + 3;
            end
        end
    endtask

    // Hold the receiver off while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_cycles <= 0;
        hold_off <= 1'b1;
        test_random(40);
    endtask

    initial
    begin
        int drain;
        error_count = 0;
        cycle_count = 0;
        hold_off = 1'b0;
        hold_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_NOP;
        address = '0;
        write_data = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
            shadow_store[i] = '0;
        for (int i = 0; i < BUF_ENTRIES; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_addr[i] = '0;
            slot_value[i] = '0;
        end
        shadow_phase = PH_NONE;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random(1780);
        in_valid <= 1'b0;

        drain = 0;
        while (pending_results.size() > 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
